FILE: hw/rtl/lmc_pkg.sv
`timescale 1ns / 1ps
package lmc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned StepW   = 7;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned FadeW   = 9;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [MsW-1:0]    DebounceReset = 16'd50;
  localparam logic [MsW-1:0]    HoldoffReset  = 16'd500;
  localparam logic [MsW-1:0]    BlinkReset    = 16'd500;
  localparam logic [StepW-1:0]  FadeStepReset = 7'd5;
  localparam logic [LevelW-1:0] LevelFull     = 8'd255;
  localparam logic [LevelW-1:0] LevelDark     = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE,
    REG_HOLDOFF,
    REG_BLINK,
    REG_FADE_STEP
  } lmc_reg_t;

  typedef enum logic [ModeW-1:0] {
    MODE_DARK,
    MODE_BLINK,
    MODE_ON,
    MODE_FADE
  } lmc_mode_t;

  typedef struct packed {
    logic [MsW-1:0]   debounce_ms;
    logic [MsW-1:0]   mode_holdoff_ms;
    logic [MsW-1:0]   blink_interval_ms;
    logic [StepW-1:0] fade_step;
  } lmc_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] now_ms;
    logic             button_pressed;
  } lmc_item_t;

  typedef struct packed {
    lmc_mode_t         mode;
    logic [TimeW-1:0]  last_sample_time;
    logic [TimeW-1:0]  last_change_time;
    logic [TimeW-1:0]  last_swap_time;
    logic [FadeW-1:0]  fade_level;
    logic              fade_rising;
    logic [LevelW-1:0] led_one;
    logic [LevelW-1:0] led_two;
  } lmc_state_t;

  localparam lmc_state_t StateReset = '{
    mode:             MODE_DARK,
    last_sample_time: '0,
    last_change_time: '0,
    last_swap_time:   '0,
    fade_level:       '0,
    fade_rising:      1'b1,
    led_one:          LevelDark,
    led_two:          LevelDark
  };

endpackage

FILE: hw/rtl/lmc_if.sv
`timescale 1ns / 1ps
interface lmc_in_if;
  import lmc_pkg::*;

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_ms;
  logic             button_pressed;

  modport source (output valid, output now_ms, output button_pressed, input ready);
  modport sink (input valid, input now_ms, input button_pressed, output ready);
endinterface

interface lmc_out_if;
  import lmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [LevelW-1:0] led_one_level;
  logic [LevelW-1:0] led_two_level;
  logic [ModeW-1:0]  mode;

  modport source (output valid, output led_one_level, output led_two_level, output mode,
                  input ready);
  modport sink (input valid, input led_one_level, input led_two_level, input mode,
                output ready);
endinterface

FILE: hw/rtl/led_mode_cycler_blink_fade.sv
`timescale 1ns / 1ps
// LED mode cycler with blink and fade modes.
// in_chan carries one control-loop pass per request: the millisecond time
// now_ms and the mode button level button_pressed. out_chan returns one
// result per request: both LED levels and the current mode.
// The cfg_ port writes debounce, mode holdoff, blink interval and fade step
// by index; write it only while no request is in flight.
// A request is taken into an input register, the whole pass is evaluated
// combinationally from there, and the result lands in the output register
// together with the updated state.
// Throughput is one request per clock while out_chan takes the results; the
// state update of each pass feeds the next.
// Reset (rst_n low, synchronous) clears both stages, sets mode off, LEDs at
// zero, all timestamps zero, fade rising, and the registers to their defaults.
// When out_chan stalls, the output holds its result, the input register keeps
// one more request, and in_chan.ready drops until the output is taken.
module led_mode_cycler_blink_fade (
  input  logic                          clk,
  input  logic                          rst_n,
  lmc_in_if.sink                        in_chan,
  lmc_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [lmc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [lmc_pkg::CfgW-1:0]      cfg_wdata
);
  import lmc_pkg::*;

  lmc_cfg_t          cfg;
  lmc_item_t         item;
  lmc_state_t        state_r;
  lmc_state_t        state_nxt;
  logic              advance;
  logic              out_valid_r;
  logic [LevelW-1:0] led_one_r;
  logic [LevelW-1:0] led_two_r;
  logic [ModeW-1:0]  mode_r;

  lmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lmc_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .item    (item)
  );

  lmc_step u_step (
    .cur  (state_r),
    .cfg  (cfg),
    .item (item),
    .nxt  (state_nxt)
  );

  assign advance = item.valid && (out_chan.ready || !out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StateReset;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_one_r <= state_nxt.led_one;
      led_two_r <= state_nxt.led_two;
      mode_r    <= state_nxt.mode;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.led_one_level = led_one_r;
  assign out_chan.led_two_level = led_two_r;
  assign out_chan.mode          = mode_r;
endmodule

FILE: hw/rtl/lmc_cfg.sv
`timescale 1ns / 1ps
module lmc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lmc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [lmc_pkg::CfgW-1:0]      cfg_wdata,
  output lmc_pkg::lmc_cfg_t             cfg
);
  import lmc_pkg::*;

  lmc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms       <= DebounceReset;
      cfg_r.mode_holdoff_ms   <= HoldoffReset;
      cfg_r.blink_interval_ms <= BlinkReset;
      cfg_r.fade_step         <= FadeStepReset;
    end else if (cfg_we) begin
      unique case (lmc_reg_t'(cfg_index))
        REG_DEBOUNCE:  cfg_r.debounce_ms       <= cfg_wdata[MsW-1:0];
        REG_HOLDOFF:   cfg_r.mode_holdoff_ms   <= cfg_wdata[MsW-1:0];
        REG_BLINK:     cfg_r.blink_interval_ms <= cfg_wdata[MsW-1:0];
        REG_FADE_STEP: cfg_r.fade_step         <= cfg_wdata[StepW-1:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

FILE: hw/rtl/lmc_in_stage.sv
`timescale 1ns / 1ps
module lmc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  lmc_in_if.sink              in_chan,
  input  logic                advance,
  output lmc_pkg::lmc_item_t  item
);
  import lmc_pkg::*;

  logic             valid_r;
  logic [TimeW-1:0] now_r;
  logic             button_r;
  logic             take;

  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      now_r    <= in_chan.now_ms;
      button_r <= in_chan.button_pressed;
    end
  end

  assign item.valid          = valid_r;
  assign item.now_ms         = now_r;
  assign item.button_pressed = button_r;
endmodule

FILE: hw/rtl/lmc_step.sv
`timescale 1ns / 1ps
module lmc_step (
  input  lmc_pkg::lmc_state_t  cur,
  input  lmc_pkg::lmc_cfg_t    cfg,
  input  lmc_pkg::lmc_item_t   item,
  output lmc_pkg::lmc_state_t  nxt
);
  import lmc_pkg::*;

  always_comb begin
    lmc_state_t         s;
    logic [TimeW-1:0]   sample_diff;
    logic [TimeW-1:0]   change_diff;
    logic [TimeW-1:0]   swap_diff;
    logic               sample;
    logic               accept;
    logic signed [FadeW:0] lvl;
    logic signed [FadeW:0] step_s;

    s           = cur;
    sample_diff = item.now_ms - cur.last_sample_time;
    change_diff = item.now_ms - cur.last_change_time;
    sample      = sample_diff > {{(TimeW-MsW){1'b0}}, cfg.debounce_ms};
    accept      = sample && item.button_pressed &&
                  (change_diff >= {{(TimeW-MsW){1'b0}}, cfg.mode_holdoff_ms});

    if (sample) begin
      s.last_sample_time = item.now_ms;
    end

    if (accept) begin
      s.mode             = lmc_mode_t'(cur.mode + 2'd1);
      s.last_change_time = item.now_ms;
      unique case (s.mode)
        MODE_DARK: begin
          s.led_one = LevelDark;
          s.led_two = LevelDark;
        end
        MODE_BLINK: begin
          s.last_swap_time = item.now_ms;
          s.led_one        = LevelFull;
          s.led_two        = LevelDark;
        end
        MODE_ON: begin
          s.led_one = LevelFull;
          s.led_two = LevelFull;
        end
        MODE_FADE: begin
          s.fade_level  = '0;
          s.fade_rising = 1'b1;
        end
        default: s = s;
      endcase
    end

    swap_diff = item.now_ms - s.last_swap_time;
    step_s    = $signed({{(FadeW+1-StepW){1'b0}}, cfg.fade_step});
    lvl       = $signed({1'b0, s.fade_level});

    unique case (s.mode)
      MODE_BLINK: begin
        if (swap_diff >= {{(TimeW-MsW){1'b0}}, cfg.blink_interval_ms}) begin
          s.last_swap_time = item.now_ms;
          if (s.led_one == LevelFull) begin
            s.led_one = LevelDark;
            s.led_two = LevelFull;
          end else begin
            s.led_one = LevelFull;
            s.led_two = LevelDark;
          end
        end
      end
      MODE_FADE: begin
        s.led_one = s.fade_level[LevelW-1:0];
        s.led_two = s.fade_level[LevelW-1:0];
        lvl = s.fade_rising ? (lvl + step_s) : (lvl - step_s);
        if (lvl <= 0 || lvl >= $signed({2'b00, LevelFull})) begin
          // bounce: flip direction, step back to where it was
          s.fade_rising = !s.fade_rising;
        end else begin
          s.fade_level = lvl[FadeW-1:0];
        end
      end
      default: s = s;
    endcase

    nxt = s;
  end
endmodule

FILE: test/led_level_checker.sv
`timescale 1ns / 1ps
module led_level_checker
  import lmc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  lmc_in_if                           in_mon,
  lmc_out_if                          out_mon,
  input  logic                        cfg_we,
  input  logic [lmc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lmc_pkg::CfgW-1:0]    cfg_wdata,
  output int                          mismatches,
  output int                          outstanding
);

  typedef struct packed {
    logic [LevelW-1:0] led_one;
    logic [LevelW-1:0] led_two;
    lmc_mode_t         mode;
  } led_result_t;

  lmc_state_t  pass_state;
  lmc_cfg_t    live_cfg;
  led_result_t expected_levels[$];

  function automatic lmc_state_t next_pass_state(input lmc_state_t s, input lmc_cfg_t c,
                                                 input logic [TimeW-1:0] now,
                                                 input logic pressed);
    logic [TimeW-1:0] since;
    logic [ModeW-1:0] m;
    int lvl;
    int stp;
    since = now - s.last_sample_time;
    if (since > TimeW'(c.debounce_ms)) begin
      since = now - s.last_change_time;
      if (pressed && since >= TimeW'(c.mode_holdoff_ms)) begin
        m = s.mode;
        m = m + 2'd1;
        s.mode = lmc_mode_t'(m);
        case (s.mode)
          MODE_DARK: begin
            s.led_one = LevelDark;
            s.led_two = LevelDark;
          end
          MODE_BLINK: begin
            s.last_swap_time = now;
            s.led_one = LevelFull;
            s.led_two = LevelDark;
          end
          MODE_ON: begin
            s.led_one = LevelFull;
            s.led_two = LevelFull;
          end
          default: begin
            s.fade_level = '0;
            s.fade_rising = 1'b1;
          end
        endcase
        s.last_change_time = now;
      end
      s.last_sample_time = now;
    end
    case (s.mode)
      MODE_BLINK: begin
        since = now - s.last_swap_time;
        if (since >= TimeW'(c.blink_interval_ms)) begin
          s.last_swap_time = now;
          if (s.led_one == LevelFull) begin
            s.led_one = LevelDark;
            s.led_two = LevelFull;
          end else begin
            s.led_one = LevelFull;
            s.led_two = LevelDark;
          end
        end
      end
      MODE_FADE: begin
        s.led_one = s.fade_level[LevelW-1:0];
        s.led_two = s.fade_level[LevelW-1:0];
        lvl = int'(s.fade_level);
        stp = int'(c.fade_step);
        lvl += s.fade_rising ? stp : -stp;
        // bounce off either end
        if (lvl <= 0 || lvl >= 255) begin
          s.fade_rising = !s.fade_rising;
          lvl += s.fade_rising ? stp : -stp;
        end
        s.fade_level = lvl[FadeW-1:0];
      end
      default: ;
    endcase
    return s;
  endfunction

  always @(posedge clk) begin
    led_result_t want;
    if (!rst_n) begin
      pass_state = StateReset;
      live_cfg = '{debounce_ms: DebounceReset, mode_holdoff_ms: HoldoffReset,
                   blink_interval_ms: BlinkReset, fade_step: FadeStepReset};
      expected_levels.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result led %0d/%0d mode %0d", $time,
                     out_mon.led_one_level, out_mon.led_two_level, out_mon.mode);
        end else begin
          want = expected_levels.pop_front();
          if (out_mon.led_one_level !== want.led_one ||
              out_mon.led_two_level !== want.led_two ||
              out_mon.mode !== want.mode) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected led %0d/%0d mode %0d, got led %0d/%0d mode %0d",
                       $time, want.led_one, want.led_two, want.mode,
                       out_mon.led_one_level, out_mon.led_two_level, out_mon.mode);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pass_state = next_pass_state(pass_state, live_cfg, in_mon.now_ms,
                                     in_mon.button_pressed);
        expected_levels.push_back('{led_one: pass_state.led_one,
                                    led_two: pass_state.led_two,
                                    mode: pass_state.mode});
      end
      if (cfg_we) begin
        case (lmc_reg_t'(cfg_index))
          REG_DEBOUNCE:  live_cfg.debounce_ms = cfg_wdata;
          REG_HOLDOFF:   live_cfg.mode_holdoff_ms = cfg_wdata;
          REG_BLINK:     live_cfg.blink_interval_ms = cfg_wdata;
          REG_FADE_STEP: live_cfg.fade_step = cfg_wdata[StepW-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_levels.size();
  end

endmodule

FILE: test/tb_led_mode_cycler_blink_fade.sv
`timescale 1ns / 1ps
module tb_led_mode_cycler_blink_fade;
  import lmc_pkg::*;

  localparam int PhaseCount      = 8;
  localparam int PassesPerPhase  = 180;
  localparam int LongStallCycles = 300;
  localparam int QuietLimit      = 4000;
  localparam int DrainCycles     = 4;
  localparam int DirectedCount   = 17;

  typedef struct packed {
    int debounce;
    int holdoff;
    int blink;
    int step;
    int delta_max;
    int press_pct;
  } phase_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now;
    logic             pressed;
  } pass_t;

  localparam phase_cfg_t Phases [PhaseCount] = '{
    '{50,    500,   500,   5,   200,   30},
    '{0,     0,     0,     0,   3,     50},
    '{65535, 65535, 65535, 127, 40000, 50},
    '{10,    2000,  1,     1,   20,    20},
    '{100,   300,   250,   64,  150,   40},
    '{5,     5000,  37,    3,   30,    10},
    '{1,     1,     2,     126, 4,     60},
    '{50,    500,   500,   5,   120,   35}
  };

  localparam pass_t DirectedPasses [DirectedCount] = '{
    '{32'd0, 1'b1},
    '{32'd51, 1'b1},
    '{32'd600, 1'b1},
    '{32'd1099, 1'b0},
    '{32'd1100, 1'b0},
    '{32'd1100, 1'b1},
    '{32'd1150, 1'b1},
    '{32'd1151, 1'b1},
    '{32'd1650, 1'b1},
    '{32'd1651, 1'b1},
    '{32'd1700, 1'b0},
    '{32'd1701, 1'b0},
    '{32'hFFFF_FFFF, 1'b1},
    '{32'h0000_0100, 1'b1},
    '{32'h0000_0300, 1'b1},
    '{32'h8000_0000, 1'b0},
    '{32'h8000_0000, 1'b0}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_wdata;
  int                  mismatches;
  int                  outstanding;
  int                  quiet_cycles;
  int                  stall_kick;
  int                  rx_stall_pct;
  int                  send_idle_pct;

  lmc_in_if  in_chan ();
  lmc_out_if out_chan ();

  led_mode_cycler_blink_fade u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  led_level_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // hold ready low for a long stretch on each kick
  initial begin
    int hold_left;
    int kick_seen;
    hold_left = 0;
    kick_seen = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_kick != kick_seen) begin
        kick_seen = stall_kick;
        hold_left = LongStallCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_pass(input logic [TimeW-1:0] now, input logic pressed);
    in_chan.valid <= 1'b1;
    in_chan.now_ms <= now;
    in_chan.button_pressed <= pressed;
    do @(posedge clk); while (!in_chan.ready);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      in_chan.now_ms <= $urandom;
      in_chan.button_pressed <= 1'($urandom_range(1));
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input lmc_reg_t idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgW'(value);
    @(posedge clk);
  endtask

  initial begin
    phase_cfg_t       ph;
    logic [TimeW-1:0] now_cur;
    logic [TimeW-1:0] delta;
    int               pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.now_ms = '0;
    in_chan.button_pressed = 1'b0;
    stall_kick = 0;
    rx_stall_pct = 0;
    send_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DirectedCount; i++)
      send_pass(DirectedPasses[i].now, DirectedPasses[i].pressed);
    now_cur = DirectedPasses[DirectedCount-1].now;

    for (int p = 0; p < PhaseCount; p++) begin
      ph = Phases[p];
      drain_results();
      write_reg(REG_DEBOUNCE, ph.debounce);
      write_reg(REG_HOLDOFF, ph.holdoff);
      write_reg(REG_BLINK, ph.blink);
      write_reg(REG_FADE_STEP, ph.step);
      cfg_we <= 1'b0;
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 48;
          rx_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          rx_stall_pct <= 48;
        end
        default: begin
          send_idle_pct = 25;
          rx_stall_pct <= 25;
        end
      endcase
      for (int n = 0; n < PassesPerPhase; n++) begin
        if (p % 4 == 0 && n == 60)
          stall_kick <= stall_kick + 1;
        pick = $urandom_range(99);
        if (pick < 6)
          delta = '0;
        else if (pick < 10)
          delta = $urandom;
        else if (pick < 16)
          delta = TimeW'(ph.debounce + $urandom_range(1));
        else if (pick < 20)
          delta = TimeW'(ph.holdoff);
        else
          delta = TimeW'($urandom_range(ph.delta_max));
        now_cur = now_cur + delta;
        send_pass(now_cur, $urandom_range(99) < ph.press_pct);
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
